FILE: rtl/qts_pkg.sv
// qts_pkg: shared widths, codes, coefficient microcode and wide-word helpers
// for the quintic trajectory sampler
// no dependencies

package qts_pkg;

    // word widths
    localparam int BIG_W   = 320;
    localparam int LIMB_W  = 32;
    localparam int LIMBS   = BIG_W / LIMB_W;
    localparam int PROD_W  = 2 * LIMB_W;
    localparam int CFG_W   = 64;
    localparam int DUR_W   = 32;
    localparam int TIME_W  = 32;
    localparam int OUT_W   = 64;
    localparam int DPOW_W  = 5 * DUR_W;
    localparam int QBITS   = OUT_W - 1;
    localparam int REM_W   = DPOW_W + QBITS + 1;

    // pipeline shape
    localparam int HORNER_STEPS = 5;
    localparam int LANES        = 4;
    localparam int DIV_DEPTH    = QBITS + 1;
    localparam int PIPE_DEPTH   = 1 + 2 * HORNER_STEPS + DIV_DEPTH;

    // lanes of the evaluator
    localparam int LANE_POS  = 0;
    localparam int LANE_VEL  = 1;
    localparam int LANE_ACC  = 2;
    localparam int LANE_JERK = 3;

    // scaling of the numerators
    localparam int V_SCALE    = 17;
    localparam int JERK_SCALE = 15;
    localparam int LANE_SHIFT [LANES] = '{33, 17, 1, 0};

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_START_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_VEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_VEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_ACC = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_ACC   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_DUR  = 3'd6;
    localparam logic [DUR_W-1:0]     DUR_RESET     = 32'h0001_0000;

    // coefficient microcode
    localparam int UCODE_LEN = 52;
    localparam int STEP_W    = $clog2(UCODE_LEN);
    localparam int STEP_LAST = UCODE_LEN - 1;
    localparam int KVAL_W    = 17;
    localparam logic [KVAL_W-1:0] K_2P16 = 17'd65536;

    typedef enum logic [1:0] {OP_LOAD, OP_ADD, OP_SUB} op_t;

    typedef enum logic [3:0] {
        SRC_Q0, SRC_Q1, SRC_V0, SRC_V1, SRC_A0, SRC_A1, SRC_ACC,
        SRC_B0, SRC_B1, SRC_B2, SRC_B3, SRC_B4, SRC_ONE
    } src_t;

    typedef enum logic {MUL_DUR, MUL_KVAL} mul_t;

    typedef enum logic [3:0] {
        DST_NONE, DST_B0, DST_B1, DST_B2, DST_B3, DST_B4, DST_K3D2,
        DST_K4D, DST_K5, DST_A0D5, DST_V0D5, DST_Q0D5X, DST_DPOW
    } dst_t;

    typedef struct packed {
        op_t               op;
        src_t              src;
        mul_t              msel;
        logic [KVAL_W-1:0] kval;
        dst_t              dst;
        logic              last;
    } uop_t;

    // one result word
    typedef struct packed {
        logic [OUT_W-1:0] position;
        logic [OUT_W-1:0] velocity;
        logic [OUT_W-1:0] acceleration;
        logic [OUT_W-1:0] jerk;
    } res_t;

    function automatic uop_t mk(input op_t op, input src_t src, input mul_t msel,
                                input logic [KVAL_W-1:0] kval, input dst_t dst);
        uop_t u;
        u.op   = op;
        u.src  = src;
        u.msel = msel;
        u.kval = kval;
        u.dst  = dst;
        u.last = 1'b0;
        return u;
    endfunction

    // boundary terms, the three polynomial numerators, then powers of the duration
    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        case (int'(step))
            0:  u = mk(OP_LOAD, SRC_Q1,  MUL_KVAL, 17'd1,  DST_NONE);
            1:  u = mk(OP_SUB,  SRC_Q0,  MUL_KVAL, 17'd1,  DST_NONE);
            2:  u = mk(OP_LOAD, SRC_ACC, MUL_KVAL, K_2P16, DST_NONE);
            3:  u = mk(OP_LOAD, SRC_ACC, MUL_KVAL, K_2P16, DST_B0);
            4:  u = mk(OP_LOAD, SRC_V1,  MUL_DUR,  17'd0,  DST_NONE);
            5:  u = mk(OP_LOAD, SRC_ACC, MUL_KVAL, K_2P16, DST_B1);
            6:  u = mk(OP_LOAD, SRC_V0,  MUL_DUR,  17'd0,  DST_NONE);
            7:  u = mk(OP_LOAD, SRC_ACC, MUL_KVAL, K_2P16, DST_B2);
            8:  u = mk(OP_LOAD, SRC_A0,  MUL_DUR,  17'd0,  DST_NONE);
            9:  u = mk(OP_LOAD, SRC_ACC, MUL_DUR,  17'd0,  DST_B3);
            10: u = mk(OP_LOAD, SRC_A1,  MUL_DUR,  17'd0,  DST_NONE);
            11: u = mk(OP_LOAD, SRC_ACC, MUL_DUR,  17'd0,  DST_B4);
            12: u = mk(OP_LOAD, SRC_B0,  MUL_KVAL, 17'd20, DST_NONE);
            13: u = mk(OP_SUB,  SRC_B1,  MUL_KVAL, 17'd8,  DST_NONE);
            14: u = mk(OP_SUB,  SRC_B2,  MUL_KVAL, 17'd12, DST_NONE);
            15: u = mk(OP_SUB,  SRC_B3,  MUL_KVAL, 17'd3,  DST_NONE);
            16: u = mk(OP_ADD,  SRC_B4,  MUL_KVAL, 17'd1,  DST_NONE);
            17: u = mk(OP_LOAD, SRC_ACC, MUL_DUR,  17'd0,  DST_NONE);
            18: u = mk(OP_LOAD, SRC_ACC, MUL_DUR,  17'd0,  DST_K3D2);
            19: u = mk(OP_LOAD, SRC_B1,  MUL_KVAL, 17'd14, DST_NONE);
            20: u = mk(OP_ADD,  SRC_B2,  MUL_KVAL, 17'd16, DST_NONE);
            21: u = mk(OP_ADD,  SRC_B3,  MUL_KVAL, 17'd3,  DST_NONE);
            22: u = mk(OP_SUB,  SRC_B4,  MUL_KVAL, 17'd2,  DST_NONE);
            23: u = mk(OP_SUB,  SRC_B0,  MUL_KVAL, 17'd30, DST_NONE);
            24: u = mk(OP_LOAD, SRC_ACC, MUL_DUR,  17'd0,  DST_K4D);
            25: u = mk(OP_LOAD, SRC_B0,  MUL_KVAL, 17'd12, DST_NONE);
            26: u = mk(OP_SUB,  SRC_B1,  MUL_KVAL, 17'd6,  DST_NONE);
            27: u = mk(OP_SUB,  SRC_B2,  MUL_KVAL, 17'd6,  DST_NONE);
            28: u = mk(OP_SUB,  SRC_B3,  MUL_KVAL, 17'd1,  DST_NONE);
            29: u = mk(OP_ADD,  SRC_B4,  MUL_KVAL, 17'd1,  DST_K5);
            30: u = mk(OP_LOAD, SRC_A0,  MUL_DUR,  17'd0,  DST_NONE);
            34: u = mk(OP_LOAD, SRC_ACC, MUL_DUR,  17'd0,  DST_A0D5);
            35: u = mk(OP_LOAD, SRC_V0,  MUL_DUR,  17'd0,  DST_NONE);
            39: u = mk(OP_LOAD, SRC_ACC, MUL_DUR,  17'd0,  DST_V0D5);
            40: u = mk(OP_LOAD, SRC_Q0,  MUL_DUR,  17'd0,  DST_NONE);
            45: u = mk(OP_LOAD, SRC_ACC, MUL_KVAL, K_2P16, DST_Q0D5X);
            46: u = mk(OP_LOAD, SRC_ONE, MUL_DUR,  17'd0,  DST_NONE);
            50: u = mk(OP_LOAD, SRC_ACC, MUL_DUR,  17'd0,  DST_DPOW);
            31, 32, 33, 36, 37, 38, 41, 42, 43, 44, 47, 48, 49:
                u = mk(OP_LOAD, SRC_ACC, MUL_DUR,  17'd0,  DST_NONE);
            default:
                u = mk(OP_LOAD, SRC_ONE, MUL_KVAL, 17'd0,  DST_NONE);
        endcase
        u.last = (int'(step) >= STEP_LAST);
        return u;
    endfunction

    // sign extension of a boundary value
    function automatic logic [BIG_W-1:0] big_from(input logic [CFG_W-1:0] x);
        return {{(BIG_W - CFG_W){x[CFG_W-1]}}, x};
    endfunction

    // independent 32x32 limb products of a wide word and a 32-bit factor
    function automatic logic [LIMBS*PROD_W-1:0] limb_prod(input logic [BIG_W-1:0] a,
                                                          input logic [LIMB_W-1:0] m);
        logic [LIMBS*PROD_W-1:0] r;
        r = '0;
        for (int i = 0; i < LIMBS; i++) begin
            r[i*PROD_W +: PROD_W] = PROD_W'(a[i*LIMB_W +: LIMB_W]) * PROD_W'(m);
        end
        return r;
    endfunction

    // even and odd limb products do not overlap, so the sum is one add
    function automatic logic [BIG_W-1:0] limbs_sum(input logic [LIMBS*PROD_W-1:0] pp);
        logic [BIG_W-1:0] ev;
        logic [BIG_W-1:0] od;
        ev = '0;
        od = '0;
        for (int i = 0; i < LIMBS; i++) begin
            if (i % 2 == 0)
                ev = ev | (BIG_W'(pp[i*PROD_W +: PROD_W]) << (i * LIMB_W));
            else
                od = od | (BIG_W'(pp[i*PROD_W +: PROD_W]) << (i * LIMB_W));
        end
        return ev + od;
    endfunction

endpackage

FILE: rtl/qts_div.sv
// qts_div: pipelined floor division of a wide signed numerator by a power
// of the move duration, one quotient bit per stage, saturated to 64 bits
// depends on qts_pkg

module qts_div
    import qts_pkg::*;
#(
    parameter int NUM_SHIFT = 0
)
(
    input  logic              clk,
    input  logic              en,
    input  logic [BIG_W-1:0]  num,
    input  logic [DPOW_W-1:0] dpow,
    output logic [OUT_W-1:0]  quot
);

    logic [BIG_W-1:0] mag;
    logic [BIG_W-1:0] mag_sh;
    logic             ovf;
    logic [OUT_W-1:0] base;

    logic [REM_W-1:0] rem_reg [DIV_DEPTH];
    logic [QBITS-1:0] q_reg   [DIV_DEPTH];
    logic             neg_reg [DIV_DEPTH];
    logic             ovf_reg [DIV_DEPTH];

    // floor of a negative value goes through the complement
    assign mag    = num[BIG_W-1] ? ~num : num;
    assign mag_sh = mag >> NUM_SHIFT;
    assign ovf    = mag_sh >= (BIG_W'(dpow) << QBITS);

    // entry stage: magnitude and range check
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= mag_sh[REM_W-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= num[BIG_W-1];
            ovf_reg[0] <= ovf;
        end
    end

    // restoring steps, most significant quotient bit first
    for (genvar g = 1; g < DIV_DEPTH; g++)
    begin : g_step
        localparam int BITPOS = QBITS - g;
        logic [REM_W-1:0] dsh;
        logic             fits;

        assign dsh  = REM_W'(dpow) << BITPOS;
        assign fits = rem_reg[g-1] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g] <= fits ? rem_reg[g-1] - dsh : rem_reg[g-1];
                q_reg[g]   <= q_reg[g-1] | (QBITS'(fits) << BITPOS);
                neg_reg[g] <= neg_reg[g-1];
                ovf_reg[g] <= ovf_reg[g-1];
            end
        end
    end

    // clip and restore the sign
    assign base = ovf_reg[DIV_DEPTH-1] ? {1'b0, {QBITS{1'b1}}}
                                       : {1'b0, q_reg[DIV_DEPTH-1]};
    assign quot = neg_reg[DIV_DEPTH-1] ? ~base : base;

endmodule

FILE: rtl/quintic_trajectory_sampler.sv
// quintic_trajectory_sampler: quintic motion profile sampler, top level
// holds configuration, coefficient sequencer, horner pipeline, output skid
// depends on qts_pkg and qts_div
//
// Usage
//   Configuration: cfg_wr_en with cfg_wr_index (0..6) and cfg_wr_data writes
//   one boundary value or the move duration. Each write (and reset) starts a
//   coefficient pass on a shared 320x32 multiply-add unit; in_stall stays
//   high during the pass, so samples always see the new move.
//   Input channel: in_valid / in_stall carry a sample_time word (Q16.16).
//   Output channel: out_valid / out_stall carry position, velocity,
//   acceleration and jerk (signed, saturated) for that time.
//   Throughput: one word per cycle while in_stall is low; acceptance to
//   out_valid runs through 1 input stage, 10 horner stages and 64 divider
//   stages of the one-bit-per-stage division by duration^5.
//   Stall: the output register is backed by one skid entry; when the receiver
//   stalls, the pipeline runs on until the next word enters the skid, then
//   freezes and raises in_stall until the skid drains. Nothing is lost or repeated.
//   Reset: the configuration registers return to a zero move of duration
//   1.0 and the coefficient pass runs before the first sample is taken.

module quintic_trajectory_sampler
    import qts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_W-1:0]    sample_time,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [OUT_W-1:0]     position,
    output logic [OUT_W-1:0]     velocity,
    output logic [OUT_W-1:0]     acceleration,
    output logic [OUT_W-1:0]     jerk
);

    // configuration registers
    logic [CFG_W-1:0] start_position_reg;
    logic [CFG_W-1:0] end_position_reg;
    logic [CFG_W-1:0] start_velocity_reg;
    logic [CFG_W-1:0] end_velocity_reg;
    logic [CFG_W-1:0] start_accel_reg;
    logic [CFG_W-1:0] end_accel_reg;
    logic [DUR_W-1:0] move_duration_reg;
    logic [DUR_W-1:0] dur_eff;

    // coefficient sequencer
    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    uop_t              uop;
    logic [BIG_W-1:0]  src_val;
    logic [LIMB_W-1:0] mval;
    logic [BIG_W-1:0]  prod;
    logic [BIG_W-1:0]  seq_acc_next;
    logic [BIG_W-1:0]  seq_acc_reg;
    logic [BIG_W-1:0]  b0_reg, b1_reg, b2_reg, b3_reg, b4_reg;
    logic [BIG_W-1:0]  k3d2_reg, k4d_reg, k5_reg, a0d5_reg, v0d5_reg, q0d5x_reg;
    logic [DPOW_W-1:0] dpow_reg;
    logic [BIG_W-1:0]  term_reg [LANES][HORNER_STEPS];

    // evaluation pipeline
    logic                    adv;
    logic                    v_reg    [PIPE_DEPTH];
    logic [TIME_W-1:0]       tau_reg  [2*HORNER_STEPS];
    logic [LIMBS*PROD_W-1:0] prod_reg [HORNER_STEPS][LANES];
    logic [BIG_W-1:0]        acc_reg  [HORNER_STEPS][LANES];
    logic [OUT_W-1:0]        quot     [LANES];
    res_t                    res_word;

    // output register and skid
    logic out_valid_reg;
    logic skid_valid_reg;
    logic pop;
    res_t out_reg;
    res_t skid_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_position_reg <= '0;
            end_position_reg   <= '0;
            start_velocity_reg <= '0;
            end_velocity_reg   <= '0;
            start_accel_reg    <= '0;
            end_accel_reg      <= '0;
            move_duration_reg  <= DUR_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_wr_index)
                REG_START_POS: start_position_reg <= cfg_wr_data;
                REG_END_POS:   end_position_reg   <= cfg_wr_data;
                REG_START_VEL: start_velocity_reg <= cfg_wr_data;
                REG_END_VEL:   end_velocity_reg   <= cfg_wr_data;
                REG_START_ACC: start_accel_reg    <= cfg_wr_data;
                REG_END_ACC:   end_accel_reg      <= cfg_wr_data;
                REG_MOVE_DUR:  move_duration_reg  <= cfg_wr_data[DUR_W-1:0];
                default:       ;
            endcase
        end
    end

    // a zero duration counts as one lsb
    assign dur_eff = (move_duration_reg == '0) ? DUR_W'(1) : move_duration_reg;

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (uop.last)
                busy_reg <= 1'b0;
            else
                step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign uop = uop_at(step_reg);

    // operand select
    always_comb
    begin
        case (uop.src)
            SRC_Q0:  src_val = big_from(start_position_reg);
            SRC_Q1:  src_val = big_from(end_position_reg);
            SRC_V0:  src_val = big_from(start_velocity_reg);
            SRC_V1:  src_val = big_from(end_velocity_reg);
            SRC_A0:  src_val = big_from(start_accel_reg);
            SRC_A1:  src_val = big_from(end_accel_reg);
            SRC_ACC: src_val = seq_acc_reg;
            SRC_B0:  src_val = b0_reg;
            SRC_B1:  src_val = b1_reg;
            SRC_B2:  src_val = b2_reg;
            SRC_B3:  src_val = b3_reg;
            SRC_B4:  src_val = b4_reg;
            SRC_ONE: src_val = BIG_W'(1);
            default: src_val = '0;
        endcase
    end

    // multiply-add unit
    assign mval = (uop.msel == MUL_DUR) ? dur_eff : LIMB_W'(uop.kval);
    assign prod = limbs_sum(limb_prod(src_val, mval));

    always_comb
    begin
        case (uop.op)
            OP_LOAD: seq_acc_next = prod;
            OP_ADD:  seq_acc_next = seq_acc_reg + prod;
            OP_SUB:  seq_acc_next = seq_acc_reg - prod;
            default: seq_acc_next = prod;
        endcase
    end

    // sequencer datapath and coefficient store
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            seq_acc_reg <= seq_acc_next;
            case (uop.dst)
                DST_B0:    b0_reg    <= seq_acc_next;
                DST_B1:    b1_reg    <= seq_acc_next;
                DST_B2:    b2_reg    <= seq_acc_next;
                DST_B3:    b3_reg    <= seq_acc_next;
                DST_B4:    b4_reg    <= seq_acc_next;
                DST_K3D2:  k3d2_reg  <= seq_acc_next;
                DST_K4D:   k4d_reg   <= seq_acc_next;
                DST_K5:    k5_reg    <= seq_acc_next;
                DST_A0D5:  a0d5_reg  <= seq_acc_next;
                DST_V0D5:  v0d5_reg  <= seq_acc_next;
                DST_Q0D5X: q0d5x_reg <= seq_acc_next;
                DST_DPOW:  dpow_reg  <= seq_acc_next[DPOW_W-1:0];
                default:   ;
            endcase
        end
    end

    // horner terms per lane, settled before the pass ends
    always_ff @(posedge clk)
    begin
        term_reg[LANE_POS][0]  <= k4d_reg;
        term_reg[LANE_POS][1]  <= k3d2_reg;
        term_reg[LANE_POS][2]  <= a0d5_reg;
        term_reg[LANE_POS][3]  <= v0d5_reg << V_SCALE;
        term_reg[LANE_POS][4]  <= q0d5x_reg << V_SCALE;
        term_reg[LANE_VEL][0]  <= k5_reg * BIG_W'(5);
        term_reg[LANE_VEL][1]  <= k4d_reg * BIG_W'(4);
        term_reg[LANE_VEL][2]  <= k3d2_reg * BIG_W'(3);
        term_reg[LANE_VEL][3]  <= a0d5_reg * BIG_W'(2);
        term_reg[LANE_VEL][4]  <= v0d5_reg << V_SCALE;
        term_reg[LANE_ACC][0]  <= '0;
        term_reg[LANE_ACC][1]  <= k5_reg * BIG_W'(20);
        term_reg[LANE_ACC][2]  <= k4d_reg * BIG_W'(12);
        term_reg[LANE_ACC][3]  <= k3d2_reg * BIG_W'(6);
        term_reg[LANE_ACC][4]  <= a0d5_reg * BIG_W'(2);
        term_reg[LANE_JERK][0] <= '0;
        term_reg[LANE_JERK][1] <= '0;
        term_reg[LANE_JERK][2] <= k5_reg * BIG_W'(60);
        term_reg[LANE_JERK][3] <= k4d_reg * BIG_W'(24);
        term_reg[LANE_JERK][4] <= k3d2_reg * BIG_W'(6);
    end

    // handshake: the pipeline moves while the skid is empty
    assign adv      = !skid_valid_reg;
    assign in_stall = busy_reg || skid_valid_reg || cfg_wr_en;

    // valid bits travel with the words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid && !in_stall;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // sample time line
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tau_reg[0] <= sample_time;
            for (int i = 1; i < 2 * HORNER_STEPS; i++)
            begin
                tau_reg[i] <= tau_reg[i-1];
            end
        end
    end

    // horner steps: limb products, then sum plus term
    for (genvar s = 0; s < HORNER_STEPS; s++)
    begin : g_horner
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [BIG_W-1:0] acc_in;

            if (s == 0)
            begin : g_first
                assign acc_in = (l == LANE_POS) ? k5_reg : '0;
            end
            else
            begin : g_next
                assign acc_in = acc_reg[s-1][l];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg[s][l] <= limb_prod(acc_in, tau_reg[2*s]);
                    acc_reg[s][l]  <= limbs_sum(prod_reg[s][l]) + term_reg[l][s];
                end
            end
        end
    end

    // division by duration^5, one divider per lane
    for (genvar l = 0; l < LANES; l++)
    begin : g_div
        logic [BIG_W-1:0] num;

        if (l == LANE_JERK)
        begin : g_scale
            assign num = acc_reg[HORNER_STEPS-1][l] << JERK_SCALE;
        end
        else
        begin : g_plain
            assign num = acc_reg[HORNER_STEPS-1][l];
        end

        qts_div #(
            .NUM_SHIFT (LANE_SHIFT[l])
        ) u_div (
            .clk  (clk),
            .en   (adv),
            .num  (num),
            .dpow (dpow_reg),
            .quot (quot[l])
        );
    end

    assign res_word.position     = quot[LANE_POS];
    assign res_word.velocity     = quot[LANE_VEL];
    assign res_word.acceleration = quot[LANE_ACC];
    assign res_word.jerk         = quot[LANE_JERK];

    // output register and skid control
    assign pop = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg <= v_reg[PIPE_DEPTH-1];
        end
        else if (v_reg[PIPE_DEPTH-1])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // output register and skid data
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                out_reg <= skid_reg;
        end
        else if (!out_valid_reg || pop)
        begin
            out_reg <= res_word;
        end
        else
        begin
            skid_reg <= res_word;
        end
    end

    assign out_valid    = out_valid_reg;
    assign position     = out_reg.position;
    assign velocity     = out_reg.velocity;
    assign acceleration = out_reg.acceleration;
    assign jerk         = out_reg.jerk;

`ifndef SYNTHESIS
    // no sample enters while coefficients are being rebuilt
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall)
        else $error("sample taken during coefficient pass");

    // a configuration write restarts the coefficient pass
    a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (busy_reg && step_reg == '0))
        else $error("configuration write did not restart coefficient pass");

    // the skid only fills behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a word while output register is empty");
`endif

endmodule

FILE: verif/quintic_trajectory_sampler_tb.sv
// quintic_trajectory_sampler_tb: self-checking bench for the quintic motion sampler
// predicts position, velocity, acceleration and jerk with exact wide-word arithmetic
// depends on qts_pkg and the quintic_trajectory_sampler rtl

`timescale 1ns / 1ps

module quintic_trajectory_sampler_tb;
    import qts_pkg::*;

    typedef logic [BIG_W-1:0] wide_t;

    localparam int IDLE_PCT   = 34;
    localparam int HOLD_LEN   = 400;
    localparam int WATCHDOG   = 3000;
    localparam int DRAIN_WAIT = 100;

    // dut signals, the inputs all known from time zero
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [TIME_W-1:0]    sample_time = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [OUT_W-1:0]     position;
    logic [OUT_W-1:0]     velocity;
    logic [OUT_W-1:0]     acceleration;
    logic [OUT_W-1:0]     jerk;

    // predictor copy of the move registers and derived coefficients
    logic [CFG_W-1:0] move_regs [7];
    logic [DUR_W-1:0] dur_eff;
    wide_t k5_c, k4d_c, k3d2_c, a0d5_c, v0d5_c, q0d5x_c;

    res_t expected_q [$];
    int   err_cnt = 0;
    int   quiet_cnt = 0;
    bit   no_idle = 1'b0;
    bit   hold_req = 1'b0;
    int   hold_cnt = 0;

    quintic_trajectory_sampler dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_time  (sample_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .position     (position),
        .velocity     (velocity),
        .acceleration (acceleration),
        .jerk         (jerk)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // wide-word helpers, all modulo 2^320
    function automatic wide_t sext(input logic [CFG_W-1:0] x);
        return {{(BIG_W - CFG_W){x[CFG_W-1]}}, x};
    endfunction

    function automatic wide_t wmul(input wide_t a, input logic [31:0] m);
        return a * wide_t'(m);
    endfunction

    function automatic wide_t wpow(input wide_t a, input logic [31:0] m, input int n);
        wide_t r;
        r = a;
        for (int i = 0; i < n; i++)
            r = wmul(r, m);
        return r;
    endfunction

    // floor division of a signed word by a positive divisor
    function automatic wide_t div_floor(input wide_t a, input logic [31:0] d);
        if (a[BIG_W-1])
            return ~((~a) / wide_t'(d));
        return a / wide_t'(d);
    endfunction

    function automatic logic [OUT_W-1:0] clip64(input wide_t a);
        if (a[BIG_W-1])
            return (&a[BIG_W-1:OUT_W-1]) ? a[OUT_W-1:0] : {1'b1, {(OUT_W-1){1'b0}}};
        return (|a[BIG_W-1:OUT_W-1]) ? {1'b0, {(OUT_W-1){1'b1}}} : a[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] scale_out(input wide_t num, input logic [31:0] p1,
                                                   input logic [31:0] p2);
        wide_t r;
        r = div_floor(div_floor(num, p1), p2);
        for (int i = 0; i < 5; i++)
            r = div_floor(r, dur_eff);
        return clip64(r);
    endfunction

    // derive the scaled polynomial coefficients from the move registers
    function automatic void update_coeffs();
        wide_t q0, q1, v0, v1, a0, a1, b0, b1, b2, b3, b4, m3, m4;
        dur_eff = (move_regs[REG_MOVE_DUR][DUR_W-1:0] == '0) ? 32'd1
                                                             : move_regs[REG_MOVE_DUR][DUR_W-1:0];
        q0 = sext(move_regs[REG_START_POS]);
        q1 = sext(move_regs[REG_END_POS]);
        v0 = sext(move_regs[REG_START_VEL]);
        v1 = sext(move_regs[REG_END_VEL]);
        a0 = sext(move_regs[REG_START_ACC]);
        a1 = sext(move_regs[REG_END_ACC]);
        b0 = wpow(q1 - q0, 32'd65536, 2);
        b1 = wmul(wmul(v1, dur_eff), 32'd65536);
        b2 = wmul(wmul(v0, dur_eff), 32'd65536);
        b3 = wpow(a0, dur_eff, 2);
        b4 = wpow(a1, dur_eff, 2);
        m3 = wmul(b0, 20) - wmul(b1, 8) - wmul(b2, 12) - wmul(b3, 3) + b4;
        m4 = wmul(b1, 14) + wmul(b2, 16) + wmul(b3, 3) - wmul(b4, 2) - wmul(b0, 30);
        k5_c    = wmul(b0, 12) - wmul(b1, 6) - wmul(b2, 6) - b3 + b4;
        k4d_c   = wmul(m4, dur_eff);
        k3d2_c  = wpow(m3, dur_eff, 2);
        a0d5_c  = wpow(a0, dur_eff, 5);
        v0d5_c  = wpow(v0, dur_eff, 5);
        q0d5x_c = wmul(wpow(q0, dur_eff, 5), 32'd65536);
    endfunction

    // kinematic state at one sample time
    function automatic res_t sample_motion(input logic [TIME_W-1:0] t);
        res_t  r;
        wide_t acc;
        acc = k5_c;
        acc = wmul(acc, t) + k4d_c;
        acc = wmul(acc, t) + k3d2_c;
        acc = wmul(acc, t) + a0d5_c;
        acc = wmul(acc, t) + wmul(v0d5_c, 32'd131072);
        acc = wmul(acc, t) + wmul(q0d5x_c, 32'd131072);
        r.position = scale_out(acc, 32'd65536, 32'd131072);

        acc = wmul(k5_c, 5);
        acc = wmul(acc, t) + wmul(k4d_c, 4);
        acc = wmul(acc, t) + wmul(k3d2_c, 3);
        acc = wmul(acc, t) + wmul(a0d5_c, 2);
        acc = wmul(acc, t) + wmul(v0d5_c, 32'd131072);
        r.velocity = scale_out(acc, 32'd131072, 32'd1);

        acc = wmul(k5_c, 20);
        acc = wmul(acc, t) + wmul(k4d_c, 12);
        acc = wmul(acc, t) + wmul(k3d2_c, 6);
        acc = wmul(acc, t) + wmul(a0d5_c, 2);
        r.acceleration = scale_out(acc, 32'd2, 32'd1);

        acc = wmul(k5_c, 60);
        acc = wmul(acc, t) + wmul(k4d_c, 24);
        acc = wmul(acc, t) + wmul(k3d2_c, 6);
        acc = wmul(acc, 32'd32768);
        r.jerk = scale_out(acc, 32'd1, 32'd1);
        return r;
    endfunction

    // send one sample word, optionally idling first
    task automatic send_sample(input logic [TIME_W-1:0] t);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_time <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_q.push_back(sample_motion(t));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (int'(idx) < 7)
        begin
            move_regs[idx] = (idx == REG_MOVE_DUR) ? {32'd0, val[DUR_W-1:0]} : val;
            update_coeffs();
        end
        @(posedge clk);
    endtask

    task automatic load_move(input logic [CFG_W-1:0] q0, input logic [CFG_W-1:0] q1,
                             input logic [CFG_W-1:0] v0, input logic [CFG_W-1:0] v1,
                             input logic [CFG_W-1:0] a0, input logic [CFG_W-1:0] a1,
                             input logic [DUR_W-1:0] d);
        wait_idle();
        write_reg(REG_START_POS, q0);
        write_reg(REG_END_POS, q1);
        write_reg(REG_START_VEL, v0);
        write_reg(REG_END_VEL, v1);
        write_reg(REG_START_ACC, a0);
        write_reg(REG_END_ACC, a1);
        write_reg(REG_MOVE_DUR, {32'd0, d});
    endtask

    function automatic logic [CFG_W-1:0] rand_value();
        logic [CFG_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0:       return v;
            1:       return {{24{v[39]}}, v[39:0]};
            default: return {{32{v[35]}}, v[35:0]};
        endcase
    endfunction

    function automatic logic [DUR_W-1:0] rand_duration();
        case ($urandom_range(4))
            0:       return $urandom;
            1:       return $urandom_range(1, 255);
            default: return $urandom_range(1, 32'h0008_0000);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [33:0] top;
        top = 34'(dur_eff) + 34'(dur_eff >> 2);
        if ($urandom_range(4) == 0 || top > 34'hFFFF_FFFF)
            return $urandom;
        return $urandom_range(0, top[31:0]);
    endfunction

    // zero move straight after reset
    task automatic test_reset_move();
        send_sample(32'd0);
        send_sample(32'h0001_0000);
        send_sample(32'hFFFF_FFFF);
    endtask

    // field extremes, zero and minimal duration, samples past the end
    task automatic test_directed();
        load_move(64'h0000_0001_0000_0000, 64'h0000_000A_0000_0000, '0, '0, '0, '0,
                  32'h0002_0000);
        send_sample(32'd0);
        send_sample(32'h0001_0000);
        send_sample(32'h0002_0000);
        send_sample(32'h0003_0000);
        load_move(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'd0);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0000);
        load_move(64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'hFFFF_FFFF_0000_0000,
                  64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_8000_0000,
                  32'd0);
        send_sample(32'd0);
        send_sample(32'd1);
        send_sample(32'd2);
        send_sample(32'hFFFF_FFFF);
        // unknown index leaves the move alone, then minimal duration
        wait_idle();
        write_reg(3'd7, 64'hDEAD_BEEF_0123_4567);
        write_reg(REG_MOVE_DUR, 64'd1);
        send_sample(32'd0);
        send_sample(32'd1);
        send_sample(32'h0000_FFFF);
        send_sample(32'h5555_AAAA);
    endtask

    // random moves with random samples
    task automatic test_random_moves(input int n_moves, input int per_move);
        for (int m = 0; m < n_moves; m++)
        begin
            load_move(rand_value(), rand_value(), rand_value(), rand_value(),
                      rand_value(), rand_value(), rand_duration());
            for (int i = 0; i < per_move; i++)
                send_sample(rand_time());
        end
    endtask

    // long receiver hold-off while samples keep coming
    task automatic test_backpressure();
        load_move(rand_value(), rand_value(), rand_value(), rand_value(),
                  rand_value(), rand_value(), rand_duration());
        hold_req = 1'b1;
        for (int i = 0; i < 120; i++)
            send_sample(rand_time());
    endtask

    // a stretch with no idling on either side
    task automatic test_full_rate();
        wait_idle();
        no_idle = 1'b1;
        test_random_moves(1, 80);
        wait_idle();
        no_idle = 1'b0;
    endtask

    // receiver stall generation
    always @(posedge clk)
    begin
        if (hold_req && hold_cnt == 0)
        begin
            hold_req = 1'b0;
            hold_cnt = HOLD_LEN;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        res_t exp_w;
        if (out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected word: pos %h vel %h acc %h jerk %h",
                             position, velocity, acceleration, jerk);
            end
            else
            begin
                exp_w = expected_q.pop_front();
                if (exp_w.position !== position || exp_w.velocity !== velocity ||
                    exp_w.acceleration !== acceleration || exp_w.jerk !== jerk)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("word mismatch: exp %h %h %h %h got %h %h %h %h",
                                 exp_w.position, exp_w.velocity, exp_w.acceleration,
                                 exp_w.jerk, position, velocity, acceleration, jerk);
                end
            end
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall) || cfg_wr_en)
            quiet_cnt = 0;
        else
            quiet_cnt = quiet_cnt + 1;
        if (quiet_cnt >= WATCHDOG)
        begin
            $display("quintic_trajectory_sampler: mismatch");
            $finish;
        end
    end

    initial
    begin
        move_regs[REG_START_POS] = '0;
        move_regs[REG_END_POS]   = '0;
        move_regs[REG_START_VEL] = '0;
        move_regs[REG_END_VEL]   = '0;
        move_regs[REG_START_ACC] = '0;
        move_regs[REG_END_ACC]   = '0;
        move_regs[REG_MOVE_DUR]  = {32'd0, DUR_RESET};
        update_coeffs();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_move();
        test_directed();
        test_random_moves(12, 35);
        test_backpressure();
        test_full_rate();
        test_random_moves(1, 10);

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0 && expected_q.size() == 0)
            $display("quintic_trajectory_sampler: match");
        else
            $display("quintic_trajectory_sampler: mismatch");
        $finish;
    end

endmodule

FILE: files.f
rtl/qts_pkg.sv
rtl/qts_div.sv
rtl/quintic_trajectory_sampler.sv
verif/quintic_trajectory_sampler_tb.sv
